[hw/rtl/fpl_pkg.sv]
// fpl_pkg: shared types, codes and defaults for the fraction list block
// no dependencies; imported by every module of the block
`timescale 1ns / 1ps

package fpl_pkg;

  localparam int DEPTH_DEF       = 16;
  localparam int VALUE_WIDTH_DEF = 16;

  // command codes of an input item
  typedef enum logic [1:0] {
    CMD_INSERT = 2'd0,
    CMD_DELETE = 2'd1,
    CMD_FIND   = 2'd2
  } fpl_command_t;

  // result status codes
  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_EMPTY    = 3'd1,
    ST_FULL     = 3'd2,
    ST_NOTFOUND = 3'd3,
    ST_ZERODEN  = 3'd4
  } fpl_status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECODE,
    S_INS_RD,
    S_INS_WR,
    S_INS_PUT,
    S_DEL_RD,
    S_DEL_WR,
    S_DEL_DONE,
    S_FIND_RD,
    S_FIND_CMP
  } fpl_state_t;

  typedef struct packed {
    logic [1:0]         command;
    logic signed [15:0] numerator;
    logic signed [15:0] denominator;
    logic [7:0]         position;
  } fpl_in_t;

  typedef struct packed {
    logic [2:0]         status;
    logic [4:0]         entry_count;
    logic [3:0]         found_index;
    logic signed [15:0] found_numerator;
    logic signed [15:0] found_denominator;
  } fpl_out_t;

  // commands from controller to datapath
  typedef struct packed {
    logic        load;
    logic        init_ins;
    logic        init_del;
    logic        init_find;
    logic        ptr_inc;
    logic        ptr_dec;
    logic        rd_prev;
    logic        rd_next;
    logic        rd_here;
    logic        wr_shift;
    logic        wr_new;
    logic        cnt_inc;
    logic        cnt_dec;
    logic        res_load;
    logic        res_found;
    fpl_status_t res_status;
  } fpl_ctl_t;

  // status from datapath to controller
  typedef struct packed {
    logic       out_free;
    logic [1:0] command;
    logic       den_zero;
    logic       empty;
    logic       full;
    logic       ins_at_end;
    logic       del_at_end;
    logic       ins_last;
    logic       del_last;
    logic       find_match;
    logic       find_last;
  } fpl_flag_t;

endpackage

[hw/rtl/fpl_datapath.sv]
// fpl_datapath: entry memory, count, pointers, cross-product compare, result register
// depends on fpl_pkg
`timescale 1ns / 1ps

module fpl_datapath
  import fpl_pkg::*;
#(
  parameter int DEPTH       = DEPTH_DEF,
  parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
  input  logic      clk,
  input  logic      rst,
  input  fpl_in_t   request,
  input  fpl_ctl_t  ctl,
  output fpl_flag_t flag,
  output fpl_out_t  result,
  output logic      result_valid,
  input  logic      result_stall
);

  localparam int CW = $clog2(DEPTH + 1);
  localparam int AW = $clog2(DEPTH);
  localparam int XW = (CW > 8) ? CW : 8;
  localparam int VW = VALUE_WIDTH;
  localparam int MW = 2 * VW;
  localparam int PW = 16 + VW;

  fpl_in_t         item;
  logic [CW-1:0]   count;
  logic [CW-1:0]   count_next;
  logic [CW-1:0]   ptr;
  logic [CW-1:0]   at;
  logic [MW-1:0]   mem [DEPTH];
  logic [MW-1:0]   rdata;
  logic [CW-1:0]   rd_addr;
  logic            rd_en;
  logic [MW-1:0]   new_word;

  logic signed [15:0]   in_num;
  logic signed [15:0]   in_den;
  logic signed [31:0]   in_num32;
  logic signed [31:0]   in_den32;
  logic signed [VW-1:0] rd_num;
  logic signed [VW-1:0] rd_den;
  logic signed [31:0]   rd_num32;
  logic signed [31:0]   rd_den32;
  logic signed [PW-1:0] prod_l;
  logic signed [PW-1:0] prod_r;

  logic [XW-1:0] pos_x;
  logic [XW-1:0] cnt_x;
  logic [XW-1:0] at_ins_x;
  logic [XW-1:0] at_del_x;
  logic [CW-1:0] at_ins;
  logic [CW-1:0] at_del;
  logic [31:0]   cnt_wide;
  logic [31:0]   idx_wide;

  assign in_num   = item.numerator;
  assign in_den   = item.denominator;
  assign in_num32 = 32'(in_num);
  assign in_den32 = 32'(in_den);
  assign new_word = {in_num32[VW-1:0], in_den32[VW-1:0]};

  assign rd_num   = rdata[MW-1:VW];
  assign rd_den   = rdata[VW-1:0];
  assign rd_num32 = 32'(rd_num);
  assign rd_den32 = 32'(rd_den);

  // exact cross products: n * stored_den == d * stored_num
  assign prod_l = PW'(in_num) * PW'(rd_den);
  assign prod_r = PW'(in_den) * PW'(rd_num);

  // clamped positions
  assign pos_x    = XW'(item.position);
  assign cnt_x    = XW'(count);
  assign at_ins_x = (pos_x < cnt_x) ? pos_x : cnt_x;
  assign at_del_x = (pos_x < cnt_x) ? pos_x : cnt_x - 1'b1;
  assign at_ins   = at_ins_x[CW-1:0];
  assign at_del   = at_del_x[CW-1:0];

  assign flag.out_free   = !result_valid || !result_stall;
  assign flag.command    = item.command;
  assign flag.den_zero   = (item.denominator == 16'sd0);
  assign flag.empty      = (count == '0);
  assign flag.full       = (count == CW'(DEPTH));
  assign flag.ins_at_end = (at_ins == count);
  assign flag.del_at_end = ((at_del + 1'b1) == count);
  assign flag.ins_last   = (ptr == (at + 1'b1));
  assign flag.del_last   = ((ptr + CW'(2)) == count);
  assign flag.find_match = (prod_l == prod_r);
  assign flag.find_last  = ((ptr + 1'b1) == count);

  assign rd_en   = ctl.rd_prev | ctl.rd_next | ctl.rd_here;
  assign rd_addr = ctl.rd_prev ? ptr - 1'b1 : (ctl.rd_next ? ptr + 1'b1 : ptr);

  always_ff @(posedge clk) begin
    if (ctl.wr_shift) begin
      mem[ptr[AW-1:0]] <= rdata;
    end else if (ctl.wr_new) begin
      mem[at[AW-1:0]] <= new_word;
    end
    if (rd_en) begin
      rdata <= mem[rd_addr[AW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      item <= request;
    end
    if (ctl.init_ins) begin
      ptr <= count;
      at  <= at_ins;
    end else if (ctl.init_del) begin
      ptr <= at_del;
    end else if (ctl.init_find) begin
      ptr <= '0;
    end else if (ctl.ptr_inc) begin
      ptr <= ptr + 1'b1;
    end else if (ctl.ptr_dec) begin
      ptr <= ptr - 1'b1;
    end
  end

  always_comb begin
    count_next = count;
    if (ctl.cnt_inc) begin
      count_next = count + 1'b1;
    end else if (ctl.cnt_dec) begin
      count_next = count - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else begin
      count <= count_next;
    end
  end

  assign cnt_wide = 32'(count_next);
  assign idx_wide = 32'(ptr);

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (ctl.res_load) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.res_load) begin
      result.status      <= ctl.res_status;
      result.entry_count <= cnt_wide[4:0];
      if (ctl.res_found) begin
        result.found_index       <= idx_wide[3:0];
        result.found_numerator   <= rd_num32[15:0];
        result.found_denominator <= rd_den32[15:0];
      end else begin
        result.found_index       <= '0;
        result.found_numerator   <= '0;
        result.found_denominator <= '0;
      end
    end
  end

endmodule

[hw/rtl/fpl_controller.sv]
// fpl_controller: command sequencer for insert, delete and find
// depends on fpl_pkg
`timescale 1ns / 1ps

module fpl_controller
  import fpl_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      request_valid,
  output logic      request_stall,
  input  fpl_flag_t flag,
  output fpl_ctl_t  ctl
);

  fpl_state_t state;
  fpl_state_t state_next;
  logic       accept;

  assign request_stall = (state != S_IDLE) || !flag.out_free;
  assign accept        = request_valid && !request_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (accept) state_next = S_DECODE;
      end
      S_DECODE: begin
        unique case (flag.command)
          CMD_INSERT: begin
            if (flag.den_zero || flag.full) state_next = S_IDLE;
            else if (flag.ins_at_end)       state_next = S_INS_PUT;
            else                            state_next = S_INS_RD;
          end
          CMD_DELETE: begin
            if (flag.empty)           state_next = S_IDLE;
            else if (flag.del_at_end) state_next = S_DEL_DONE;
            else                      state_next = S_DEL_RD;
          end
          CMD_FIND: begin
            if (flag.empty) state_next = S_IDLE;
            else            state_next = S_FIND_RD;
          end
          default: state_next = S_IDLE;
        endcase
      end
      S_INS_RD:   state_next = S_INS_WR;
      S_INS_WR:   state_next = flag.ins_last ? S_INS_PUT : S_INS_RD;
      S_INS_PUT:  state_next = S_IDLE;
      S_DEL_RD:   state_next = S_DEL_WR;
      S_DEL_WR:   state_next = flag.del_last ? S_DEL_DONE : S_DEL_RD;
      S_DEL_DONE: state_next = S_IDLE;
      S_FIND_RD:  state_next = S_FIND_CMP;
      S_FIND_CMP: begin
        if (flag.find_match || flag.find_last) state_next = S_IDLE;
        else                                   state_next = S_FIND_RD;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    ctl            = '0;
    ctl.res_status = ST_OK;
    ctl.load       = accept;
    unique case (state)
      S_IDLE: begin
      end
      S_DECODE: begin
        unique case (flag.command)
          CMD_INSERT: begin
            if (flag.den_zero) begin
              ctl.res_load   = 1'b1;
              ctl.res_status = ST_ZERODEN;
            end else if (flag.full) begin
              ctl.res_load   = 1'b1;
              ctl.res_status = ST_FULL;
            end else begin
              ctl.init_ins = 1'b1;
            end
          end
          CMD_DELETE: begin
            if (flag.empty) begin
              ctl.res_load   = 1'b1;
              ctl.res_status = ST_EMPTY;
            end else begin
              ctl.init_del = 1'b1;
            end
          end
          CMD_FIND: begin
            if (flag.empty) begin
              ctl.res_load   = 1'b1;
              ctl.res_status = ST_NOTFOUND;
            end else begin
              ctl.init_find = 1'b1;
            end
          end
          default: begin
            ctl.res_load = 1'b1;
          end
        endcase
      end
      S_INS_RD: ctl.rd_prev = 1'b1;
      S_INS_WR: begin
        ctl.wr_shift = 1'b1;
        ctl.ptr_dec  = 1'b1;
      end
      S_INS_PUT: begin
        ctl.wr_new   = 1'b1;
        ctl.cnt_inc  = 1'b1;
        ctl.res_load = 1'b1;
      end
      S_DEL_RD: ctl.rd_next = 1'b1;
      S_DEL_WR: begin
        ctl.wr_shift = 1'b1;
        ctl.ptr_inc  = 1'b1;
      end
      S_DEL_DONE: begin
        ctl.cnt_dec  = 1'b1;
        ctl.res_load = 1'b1;
      end
      S_FIND_RD: ctl.rd_here = 1'b1;
      S_FIND_CMP: begin
        if (flag.find_match) begin
          ctl.res_load  = 1'b1;
          ctl.res_found = 1'b1;
        end else if (flag.find_last) begin
          ctl.res_load   = 1'b1;
          ctl.res_status = ST_NOTFOUND;
        end else begin
          ctl.ptr_inc = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

endmodule

[hw/rtl/fraction_positional_list.sv]
// decode loads the result itself for rejects, find on an empty list and unused codes; insert shifts
// the entries from its slot on up and writes the new one; delete shifts the entries after its slot
// down and drops the count; find reads and compares from entry 0 to a match or the last entry; a
// shifted entry takes a read and a write step, a compared one a read and a compare step; one item at
// a time, the next taken the cycle after the result loads, and not while a stalled result waits
// synchronous active-high reset empties the list (count 0) and drops result_valid; no entry reset
`timescale 1ns / 1ps

module fraction_positional_list
  import fpl_pkg::*;
#(
  parameter int DEPTH       = DEPTH_DEF,
  parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
  input  logic     clk,
  input  logic     rst,
  // request channel
  input  logic     request_valid,
  output logic     request_stall,
  input  fpl_in_t  request,
  // result channel
  output logic     result_valid,
  input  logic     result_stall,
  output fpl_out_t result
);

  // command bundle from sequencer, status bundle back
  fpl_ctl_t  ctl;
  fpl_flag_t flag;

  // sequencer: decode, shift loops for insert and delete, scan loop for find
  fpl_controller u_ctl (
    .clk           (clk),
    .rst           (rst),
    .request_valid (request_valid),
    .request_stall (request_stall),
    .flag          (flag),
    .ctl           (ctl)
  );

  // datapath: entry memory, count and pointers, compare unit, output register
  fpl_datapath #(
    .DEPTH       (DEPTH),
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .request      (request),
    .ctl          (ctl),
    .flag         (flag),
    .result       (result),
    .result_valid (result_valid),
    .result_stall (result_stall)
  );

endmodule

[hw/rtl/fpl_checker.sv]
// fpl_checker: port-level checks on the fraction list block, bound to the top level
// depends on fpl_pkg and fraction_positional_list
`timescale 1ns / 1ps

module fpl_checker
  import fpl_pkg::*;
#(
  parameter int DEPTH = DEPTH_DEF
) (
  input logic     clk,
  input logic     rst,
  input logic     request_valid,
  input logic     request_stall,
  input fpl_in_t  request,
  input logic     result_valid,
  input logic     result_stall,
  input fpl_out_t result
);

  localparam logic [31:0] DEPTH_W = 32'(DEPTH);

  // a held result stays put
  assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> result_valid && $stable(result))
    else $error("result changed while stalled");

  // reset drops any pending result
  assert property (@(posedge clk) rst |=> !result_valid)
    else $error("result valid after reset");

  // one item at a time: busy right after an accept
  assert property (@(posedge clk) disable iff (rst)
    request_valid && !request_stall |=> request_stall)
    else $error("second item taken while busy");

  // empty status only with an empty list
  assert property (@(posedge clk) disable iff (rst)
    result_valid && (result.status == ST_EMPTY) |-> result.entry_count == 5'd0)
    else $error("empty status with nonzero count");

  // full status only with a full list
  assert property (@(posedge clk) disable iff (rst)
    result_valid && (result.status == ST_FULL) |-> result.entry_count == DEPTH_W[4:0])
    else $error("full status with list not full");

endmodule

bind fraction_positional_list fpl_checker #(.DEPTH(DEPTH)) u_fpl_checker (.*);

[dv/tb.sv]
// tb: self-checking bench for fraction_positional_list (insert, delete and find on a fraction list)
// depends on fpl_pkg and the fraction_positional_list rtl; a tracker class predicts every result
`timescale 1ns / 1ps

module tb;
  import fpl_pkg::*;

  localparam int LIST_DEPTH = DEPTH_DEF;
  // unused command code, the block answers it with ok and the count
  localparam logic [1:0] CMD_UNUSED = 2'd3;

  localparam int RANDOM_ITEMS = 1500;
  localparam int QUIET_ITEMS  = 200;
  localparam int PRESSURE_AT  = 300;
  localparam int LONG_HOLD    = 200;
  // longest command is a find that scans a full list
  localparam int DRAIN_CYCLES = 80;
  localparam int CYCLE_LIMIT  = 600000;

  // shadow copy of the list plus the queue of results still owed by the block
  class fraction_list_tracker;
    logic signed [15:0] shadow_num [LIST_DEPTH];
    logic signed [15:0] shadow_den [LIST_DEPTH];
    int unsigned        shadow_count;
    fpl_out_t           pending_results [$];
    int                 fail_count;

    function new();
      shadow_count = 0;
      fail_count   = 0;
    endfunction

    function void note_request(fpl_in_t req);
      fpl_out_t    res;
      int unsigned at;
      longint      qn, qd, sn, sd;
      res = '0;
      res.status = ST_OK;
      qn = $signed(req.numerator);
      qd = $signed(req.denominator);
      case (req.command)
        CMD_INSERT: begin
          if (req.denominator == 16'sd0) begin
            res.status = ST_ZERODEN;
          end else if (shadow_count >= LIST_DEPTH) begin
            res.status = ST_FULL;
          end else begin
            at = (req.position < shadow_count) ? req.position : shadow_count;
            for (int i = shadow_count; i > at; i--) begin
              shadow_num[i] = shadow_num[i-1];
              shadow_den[i] = shadow_den[i-1];
            end
            shadow_num[at] = req.numerator;
            shadow_den[at] = req.denominator;
            shadow_count++;
          end
        end
        CMD_DELETE: begin
          if (shadow_count == 0) begin
            res.status = ST_EMPTY;
          end else begin
            at = (req.position < shadow_count) ? req.position : shadow_count - 1;
            for (int i = at; i + 1 < shadow_count; i++) begin
              shadow_num[i] = shadow_num[i+1];
              shadow_den[i] = shadow_den[i+1];
            end
            shadow_count--;
          end
        end
        CMD_FIND: begin
          res.status = ST_NOTFOUND;
          // first entry whose cross products agree
          for (int i = 0; i < shadow_count; i++) begin
            sn = shadow_num[i];
            sd = shadow_den[i];
            if (qn * sd == qd * sn) begin
              res.status            = ST_OK;
              res.found_index       = 4'(i);
              res.found_numerator   = shadow_num[i];
              res.found_denominator = shadow_den[i];
              break;
            end
          end
        end
        default: ;
      endcase
      res.entry_count = 5'(shadow_count);
      pending_results.push_back(res);
    endfunction

    function void compare_field(string name, logic signed [31:0] want, logic signed [31:0] got);
      if (got !== want) begin
        $error("%s mismatch: expected %0d, actual %0d", name, want, got);
        fail_count++;
      end
    endfunction

    function void check_result(fpl_out_t got);
      fpl_out_t want;
      if (pending_results.size() == 0) begin
        $error("result with nothing pending: status %0d count %0d", got.status,
               got.entry_count);
        fail_count++;
        return;
      end
      want = pending_results.pop_front();
      compare_field("status", want.status, got.status);
      compare_field("entry_count", want.entry_count, got.entry_count);
      compare_field("found_index", want.found_index, got.found_index);
      compare_field("found_numerator", want.found_numerator, got.found_numerator);
      compare_field("found_denominator", want.found_denominator, got.found_denominator);
    endfunction
  endclass

  logic     clk = 1'b0;
  logic     rst;
  logic     request_valid;
  logic     request_stall;
  fpl_in_t  request;
  logic     result_valid;
  logic     result_stall;
  fpl_out_t result;

  fraction_list_tracker tracker = new();

  // shared knobs between the sender, the receiver and the sequence
  bit quiet        = 1'b0;  // last part of the run: no idling on either side
  bit idle_on      = 1'b1;  // sender idles in this stretch
  bit hold_pending = 1'b0;  // asks the receiver for one long hold-off
  int cycle_count  = 0;

  fraction_positional_list dut (
    .clk          (clk),
    .rst          (rst),
    .request_valid(request_valid),
    .request_stall(request_stall),
    .request      (request),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

  // 2 ns period
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // hard stop for a hung handshake
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("tb: FAIL");
      $finish;
    end
  end

  // result side: every result taken is checked against the tracker, sampled at the rising edge
  always @(posedge clk) begin
    if (!rst && result_valid && !result_stall) tracker.check_result(result);
  end

  // receiver stall: random bursts, open stretches, and one long hold-off on request
  initial begin
    result_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_pending) begin
        // long hold so the block keeps its result and stalls its input
        result_stall <= 1'b1;
        repeat (LONG_HOLD - 1) @(negedge clk);
        hold_pending = 1'b0;
      end else if (quiet || $urandom_range(0, 2) != 0) begin
        result_stall <= 1'b0;
        if (!quiet) repeat ($urandom_range(0, 20)) @(negedge clk);
      end else begin
        result_stall <= 1'b1;
        repeat ($urandom_range(1, 18) - 1) @(negedge clk);
      end
    end
  end

  function automatic fpl_in_t make_request(logic [1:0] cmd, int num, int den, int pos);
    fpl_in_t req;
    req.command     = cmd;
    req.numerator   = 16'(num);
    req.denominator = 16'(den);
    req.position    = 8'(pos);
    return req;
  endfunction

  // mix of full-range, small and extreme values so finds hit and products overflow 16 bits
  function automatic logic [15:0] random_value();
    logic [15:0] v;
    case ($urandom_range(0, 3))
      0: v = 16'($urandom);
      1: v = 16'(int'($urandom_range(0, 16)) - 8);
      2: begin
        case ($urandom_range(0, 3))
          0: v = 16'h8000;
          1: v = 16'h7fff;
          2: v = 16'hffff;
          default: v = 16'h0001;
        endcase
      end
      default: v = 16'(int'($urandom_range(0, 200)) - 100);
    endcase
    return v;
  endfunction

  // mostly near the live range of the list, sometimes anywhere in the field
  function automatic logic [7:0] pick_position();
    if ($urandom_range(0, 9) < 7) return 8'($urandom_range(0, tracker.shadow_count + 1));
    return 8'($urandom_range(0, 255));
  endfunction

  function automatic fpl_in_t pick_request(int ins_pct, int del_pct);
    fpl_in_t req;
    int      roll;
    int      k;
    longint  scale, sn, sd;
    roll            = $urandom_range(0, 99);
    req.numerator   = random_value();
    req.denominator = random_value();
    req.position    = pick_position();
    if (roll < 3) begin
      // noise: unused code with random content
      req.command     = CMD_UNUSED;
      req.numerator   = 16'($urandom);
      req.denominator = 16'($urandom);
      req.position    = 8'($urandom);
    end else if (roll < 3 + ins_pct) begin
      req.command = CMD_INSERT;
      if ($urandom_range(0, 19) == 0) req.denominator = '0;
    end else if (roll < 3 + ins_pct + del_pct) begin
      req.command = CMD_DELETE;
    end else begin
      req.command = CMD_FIND;
      if (tracker.shadow_count > 0 && $urandom_range(0, 9) < 6) begin
        // an equal fraction of a stored entry, scaled by 1, -1, 2, -2, 3 or -3, unscaled where that overflows
        k = $urandom_range(0, tracker.shadow_count - 1);
        case ($urandom_range(0, 5))
          0: scale = 1;
          1: scale = -1;
          2: scale = 2;
          3: scale = -2;
          4: scale = 3;
          default: scale = -3;
        endcase
        sn = longint'(tracker.shadow_num[k]) * scale;
        sd = longint'(tracker.shadow_den[k]) * scale;
        if (sn < -32768 || sn > 32767 || sd < -32768 || sd > 32767) begin
          sn = tracker.shadow_num[k];
          sd = tracker.shadow_den[k];
        end
        req.numerator   = 16'(sn);
        req.denominator = 16'(sd);
      end else if ($urandom_range(0, 9) == 0) begin
        // zero denominator probe, 0/0 or n/0
        req.denominator = '0;
        if ($urandom_range(0, 1) == 0) req.numerator = '0;
      end
    end
    return req;
  endfunction

  // hold valid low for a pause set by n
  task automatic pause_request(int n);
    @(negedge clk);
    request_valid <= 1'b0;
    repeat (n - 1) @(negedge clk);
  endtask

  // offer one item at the falling edge and wait for it to be taken
  task automatic offer_item(fpl_in_t req);
    if (!quiet && idle_on && $urandom_range(0, 3) == 0) pause_request($urandom_range(1, 18));
    @(negedge clk);
    request       <= req;
    request_valid <= 1'b1;
    do @(posedge clk); while (request_stall);
    tracker.note_request(req);
  endtask

  task automatic run_directed();
    // empty list corners
    offer_item(make_request(CMD_DELETE, 0, 0, 0));
    offer_item(make_request(CMD_FIND, 1, 1, 0));
    offer_item(make_request(CMD_UNUSED, -1, -1, 255));
    offer_item(make_request(CMD_INSERT, 7, 0, 0));
    // extremes at head, past the end and in the middle
    offer_item(make_request(CMD_INSERT, -32768, -32768, 0));
    offer_item(make_request(CMD_INSERT, 32767, 1, 255));
    offer_item(make_request(CMD_INSERT, -32768, 32767, 1));
    offer_item(make_request(CMD_INSERT, 1, 2, 0));
    // fill to the top with mixed positions
    for (int i = 0; i < LIST_DEPTH - 4; i++) begin
      offer_item(make_request(CMD_INSERT, i + 3, -(i + 5), (i * 5) % 9));
    end
    // full list, and zero denominator wins over full
    offer_item(make_request(CMD_INSERT, 3, 4, 2));
    offer_item(make_request(CMD_INSERT, 3, 0, 2));
    // find: 0/0 hits the first entry, n/0 hits nothing, scaled and sign-flipped matches
    offer_item(make_request(CMD_FIND, 0, 0, 0));
    offer_item(make_request(CMD_FIND, 5, 0, 0));
    offer_item(make_request(CMD_FIND, 2, 4, 0));
    offer_item(make_request(CMD_FIND, -32767, -1, 0));
    offer_item(make_request(CMD_FIND, 32767, 32767, 0));
    offer_item(make_request(CMD_FIND, 9999, 7, 0));
    // delete at head, past the end, middle
    offer_item(make_request(CMD_DELETE, 0, 0, 0));
    offer_item(make_request(CMD_DELETE, 0, 0, 255));
    offer_item(make_request(CMD_DELETE, 0, 0, 5));
  endtask

  task automatic run_random();
    int ins_pct;
    int del_pct;
    ins_pct = 40;
    del_pct = 30;
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      // every hundred items: new command mix and sender idling on or off
      if (n % 100 == 0) begin
        case ($urandom_range(0, 2))
          0: begin ins_pct = 60; del_pct = 15; end
          1: begin ins_pct = 33; del_pct = 30; end
          default: begin ins_pct = 15; del_pct = 55; end
        endcase
        idle_on = ($urandom_range(0, 3) != 0);
      end
      if (n == PRESSURE_AT) hold_pending = 1'b1;
      if (n >= RANDOM_ITEMS - QUIET_ITEMS) quiet = 1'b1;
      offer_item(pick_request(ins_pct, del_pct));
    end
  endtask

  initial begin
    rst           = 1'b1;
    request_valid = 1'b0;
    request       = '0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    run_directed();
    run_random();
    @(negedge clk);
    request_valid <= 1'b0;
    // drain, then a tail to catch stray results
    while (tracker.pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (tracker.fail_count == 0 && tracker.pending_results.size() == 0) begin
      $display("tb: PASS");
    end else begin
      $display("tb: FAIL");
    end
    $finish;
  end

endmodule

[sim.f]
hw/rtl/fpl_pkg.sv
hw/rtl/fpl_datapath.sv
hw/rtl/fpl_controller.sv
hw/rtl/fraction_positional_list.sv
hw/rtl/fpl_checker.sv
dv/tb.sv
